@@ rtl/tgcs_pkg.sv @@
package tgcs_pkg;

  // Field and register widths
  localparam int FUNC_W      = 2;
  localparam int ROWIDX_W    = 5;
  localparam int ROW_W       = 64;
  localparam int COUNT_W     = 16;
  localparam int MEMBER_W    = 5;
  localparam int TAXON_W     = 6;
  localparam int LOCI_W      = 7;
  localparam int GSIZE_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_COUNT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_NEXT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAXA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GSIZE = 2'd2;

  // Reset values of the registers
  localparam logic [TAXON_W-1:0] TAXA_RST  = 6'd32;
  localparam logic [LOCI_W-1:0]  LOCI_RST  = 7'd64;
  localparam logic [GSIZE_W-1:0] GSIZE_RST = 3'd3;

  typedef logic [TAXON_W-1:0] taxon_t;
  typedef logic [3:0][TAXON_W-1:0] group_t;

  // First group position: (0,1,2,3)
  localparam group_t GROUP_FIRST = {6'd3, 6'd2, 6'd1, 6'd0};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRE   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_OUTER = 4'b1000
  } state_t;

endpackage

@@ rtl/tgcs_ram.sv @@
module tgcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/taxon_group_coverage_scan.sv @@
// Taxon group coverage scan. Rows of a taxon-by-locus presence matrix are loaded one per
// item (func load); a count item walks every group of three or four distinct taxa in
// lexicographic order and reports total and present groups plus a decisive flag; a next
// item returns the next missing group at or after the cursor, which restarts on every
// load and count. Load and unused codes answer one cycle after the item is taken. A scan
// reads the last member's row for each group visited and fetches the prefix rows again
// from the changed member up each time a member below the last one moves, because every
// row comes through the single read port of the row memory; a next scan stops at the
// first missing group. Results appear on the out_ ports for exactly one cycle, marked
// by out_valid, and cannot be held off: take them when they come. For a scan, busy stays
// high from the cycle after an item is taken until its result is shown; items answered
// without a scan never raise it. Rows never loaded read as garbage and
// must not take part in a scan. Registers may be written at any time the block is idle;
// cfg_ready is always high.
module taxon_group_coverage_scan #(
  parameter int MAX_TAXA = 32,
  parameter int MAX_LOCI = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tgcs_pkg::FUNC_W-1:0]        in_func,
  input  logic [tgcs_pkg::ROWIDX_W-1:0]      in_row_index,
  input  logic [tgcs_pkg::ROW_W-1:0]         in_row_bits,
  output logic                               out_valid,
  output logic [tgcs_pkg::COUNT_W-1:0]       out_total_groups,
  output logic [tgcs_pkg::COUNT_W-1:0]       out_present_groups,
  output logic                               out_decisive,
  output logic                               out_found,
  output logic [tgcs_pkg::MEMBER_W-1:0]      out_member_a,
  output logic [tgcs_pkg::MEMBER_W-1:0]      out_member_b,
  output logic [tgcs_pkg::MEMBER_W-1:0]      out_member_c,
  output logic [tgcs_pkg::MEMBER_W-1:0]      out_member_d,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import tgcs_pkg::*;

  localparam int AW = $clog2(MAX_TAXA);
  localparam int LW = MAX_LOCI;

  // Configuration registers
  taxon_t              taxa_r;
  logic [LOCI_W-1:0]   loci_r;
  logic [GSIZE_W-1:0]  gsize_r;

  // Sequencer state
  state_t              st_r, st_nxt;
  logic                is_next_r, is_next_nxt;
  group_t              p_r, p_nxt;          // current group position
  logic [1:0]          pre_lvl_r, pre_lvl_nxt;
  logic [2:0][LW-1:0]  pref_r, pref_nxt;    // running AND of member rows per level

  // Read tags: what the row memory returns this cycle
  logic                grp_vld_r, grp_vld_nxt;
  taxon_t              grp_x_r, grp_x_nxt;
  logic                grp_below_r, grp_below_nxt;
  logic                pref_vld_r, pref_vld_nxt;
  logic [1:0]          pref_lvl_r, pref_lvl_nxt;

  // Scan counters and cursor
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [COUNT_W-1:0]  present_r, present_nxt;
  logic                miss_r, miss_nxt;
  group_t              cur_r, cur_nxt;
  logic                cur_done_r, cur_done_nxt;

  // Result registers
  logic                out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]  out_total_r, out_total_nxt;
  logic [COUNT_W-1:0]  out_present_r, out_present_nxt;
  logic                out_decisive_r, out_decisive_nxt;
  logic                out_found_r, out_found_nxt;
  logic [3:0][MEMBER_W-1:0] out_m_r, out_m_nxt;

  // Row memory
  logic                row_we;
  logic [AW-1:0]       row_raddr;
  logic [LW-1:0]       row_rdata;

  // Derived config
  taxon_t              n_eff;
  logic                k4;
  logic [1:0]          lvl_last;
  logic [1:0]          inner_pos;
  logic [7:0]          k_val;
  logic                too_few;
  logic [LW-1:0]       loc_mask;

  // Evaluation of the returned row
  logic [LW-1:0]       pref_last;
  logic                grp_present;
  logic                ev_count;
  logic                ev_hit;
  group_t              hit_g;
  group_t              scan_g;
  logic                scan_below;

  // Prefix advance
  logic                adv_ok;
  logic [1:0]          adv_lvl;
  group_t              adv_p;

  function automatic logic lex_below(input group_t g, input group_t c, input logic quad);
    logic decided;
    logic res;
    decided = 1'b0;
    res     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!decided && (i < 3 || quad)) begin
        if (g[i] < c[i]) begin
          res     = 1'b1;
          decided = 1'b1;
        end else if (g[i] > c[i]) begin
          decided = 1'b1;
        end
      end
    end
    return res;
  endfunction

  tgcs_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_TAXA)
  ) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (AW'(in_row_index)),
    .wdata (in_row_bits[LW-1:0]),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Clamp taxon count, pick group size, build the locus mask
  assign n_eff     = (32'(taxa_r) > MAX_TAXA) ? TAXON_W'(MAX_TAXA) : taxa_r;
  assign k4        = gsize_r[2];
  assign lvl_last  = k4 ? 2'd2 : 2'd1;
  assign inner_pos = k4 ? 2'd3 : 2'd2;
  assign k_val     = k4 ? 8'd4 : 8'd3;
  assign too_few   = 8'(n_eff) < k_val;

  always_comb begin
    for (int i = 0; i < LW; i++) begin
      loc_mask[i] = 32'(i) < 32'(loci_r);
    end
  end

  // Evaluate a group whose last row arrives this cycle
  assign pref_last   = k4 ? pref_r[2] : pref_r[1];
  assign grp_present = |(pref_last & row_rdata);
  assign ev_count    = grp_vld_r && !grp_below_r;
  assign ev_hit      = ev_count && !grp_present && is_next_r;

  always_comb begin
    hit_g    = p_r;
    hit_g[3] = '0;
    if (k4) begin
      hit_g[3] = grp_x_r;
    end else begin
      hit_g[2] = grp_x_r;
    end
  end

  // Group issued this cycle, for the cursor compare
  always_comb begin
    scan_g = p_r;
    if (!k4) begin
      scan_g[3] = '0;
    end
  end

  assign scan_below = is_next_r && lex_below(scan_g, cur_r, k4);

  // Move the highest prefix member that still has room, then pack the ones above it
  always_comb begin
    adv_ok  = 1'b0;
    adv_lvl = 2'd0;
    adv_p   = p_r;
    for (int i = 2; i >= 0; i--) begin
      if (!adv_ok && (2'(i) <= lvl_last)) begin
        if (8'(p_r[i]) + k_val - 8'(i) < 8'(n_eff)) begin
          adv_ok  = 1'b1;
          adv_lvl = 2'(i);
          for (int m = 0; m < 4; m++) begin
            if (m >= i) begin
              adv_p[m] = TAXON_W'(8'(p_r[i]) + 8'(m - i + 1));
            end
          end
        end
      end
    end
  end

  always_comb begin
    st_nxt           = st_r;
    is_next_nxt      = is_next_r;
    p_nxt            = p_r;
    pre_lvl_nxt      = pre_lvl_r;
    pref_nxt         = pref_r;
    grp_vld_nxt      = 1'b0;
    grp_x_nxt        = grp_x_r;
    grp_below_nxt    = grp_below_r;
    pref_vld_nxt     = 1'b0;
    pref_lvl_nxt     = pref_lvl_r;
    total_nxt        = total_r + COUNT_W'(ev_count);
    present_nxt      = present_r + COUNT_W'(ev_count && grp_present);
    miss_nxt         = miss_r | (ev_count && !grp_present);
    cur_nxt          = cur_r;
    cur_done_nxt     = cur_done_r;
    out_valid_nxt    = 1'b0;
    out_total_nxt    = '0;
    out_present_nxt  = '0;
    out_decisive_nxt = 1'b0;
    out_found_nxt    = 1'b0;
    out_m_nxt        = '0;
    row_we           = 1'b0;
    row_raddr        = '0;

    // Fold an arriving prefix row into its level
    if (pref_vld_r) begin
      unique case (pref_lvl_r)
        2'd0:    pref_nxt[0] = loc_mask & row_rdata;
        2'd1:    pref_nxt[1] = pref_r[0] & row_rdata;
        2'd2:    pref_nxt[2] = pref_r[1] & row_rdata;
        default: pref_nxt    = pref_r;
      endcase
    end

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_func)
            FN_LOAD: begin
              row_we        = 32'(in_row_index) < MAX_TAXA;
              cur_nxt       = GROUP_FIRST;
              cur_done_nxt  = 1'b0;
              out_valid_nxt = 1'b1;
            end
            FN_COUNT: begin
              is_next_nxt = 1'b0;
              if (too_few) begin
                out_valid_nxt    = 1'b1;
                out_decisive_nxt = 1'b1;
                cur_nxt          = GROUP_FIRST;
                cur_done_nxt     = 1'b0;
              end else begin
                p_nxt       = GROUP_FIRST;
                pre_lvl_nxt = 2'd0;
                total_nxt   = '0;
                present_nxt = '0;
                miss_nxt    = 1'b0;
                st_nxt      = ST_PRE;
              end
            end
            FN_NEXT: begin
              is_next_nxt = 1'b1;
              if (too_few || cur_done_r) begin
                out_valid_nxt = 1'b1;
                cur_done_nxt  = 1'b1;
              end else begin
                p_nxt       = GROUP_FIRST;
                pre_lvl_nxt = 2'd0;
                st_nxt      = ST_PRE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_PRE: begin
        // Fetch prefix rows from the changed level up
        row_raddr    = AW'(p_r[pre_lvl_r]);
        pref_vld_nxt = 1'b1;
        pref_lvl_nxt = pre_lvl_r;
        if (pre_lvl_r == lvl_last) begin
          st_nxt = ST_SCAN;
        end else begin
          pre_lvl_nxt = pre_lvl_r + 2'd1;
        end
      end
      ST_SCAN: begin
        // One group per cycle: read the last member's row
        row_raddr     = AW'(p_r[inner_pos]);
        grp_vld_nxt   = 1'b1;
        grp_x_nxt     = p_r[inner_pos];
        grp_below_nxt = scan_below;
        if (p_r[inner_pos] == n_eff - 6'd1) begin
          st_nxt = ST_OUTER;
        end else begin
          p_nxt[inner_pos] = p_r[inner_pos] + 6'd1;
        end
      end
      ST_OUTER: begin
        if (adv_ok) begin
          p_nxt       = adv_p;
          pre_lvl_nxt = adv_lvl;
          st_nxt      = ST_PRE;
        end else begin
          st_nxt        = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (is_next_r) begin
            cur_done_nxt = 1'b1;
          end else begin
            out_total_nxt    = total_nxt;
            out_present_nxt  = present_nxt;
            out_decisive_nxt = !miss_nxt;
            cur_nxt          = GROUP_FIRST;
            cur_done_nxt     = 1'b0;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // A missing group ends a next scan at once; drop the read in flight
    if (ev_hit) begin
      st_nxt        = ST_IDLE;
      grp_vld_nxt   = 1'b0;
      out_valid_nxt = 1'b1;
      out_found_nxt = 1'b1;
      for (int i = 0; i < 4; i++) begin
        out_m_nxt[i] = hit_g[i][MEMBER_W-1:0];
      end
      cur_nxt            = hit_g;
      cur_nxt[inner_pos] = hit_g[inner_pos] + 6'd1;
      cur_done_nxt       = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taxa_r  <= TAXA_RST;
      loci_r  <= LOCI_RST;
      gsize_r <= GSIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAXA:  taxa_r  <= cfg_data[TAXON_W-1:0];
        REG_LOCI:  loci_r  <= cfg_data[LOCI_W-1:0];
        REG_GSIZE: gsize_r <= cfg_data[GSIZE_W-1:0];
        default:   taxa_r  <= taxa_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      is_next_r   <= 1'b0;
      p_r         <= GROUP_FIRST;
      pre_lvl_r   <= 2'd0;
      grp_vld_r   <= 1'b0;
      pref_vld_r  <= 1'b0;
      pref_lvl_r  <= 2'd0;
      total_r     <= '0;
      present_r   <= '0;
      miss_r      <= 1'b0;
      cur_r       <= GROUP_FIRST;
      cur_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      is_next_r   <= is_next_nxt;
      p_r         <= p_nxt;
      pre_lvl_r   <= pre_lvl_nxt;
      grp_vld_r   <= grp_vld_nxt;
      pref_vld_r  <= pref_vld_nxt;
      pref_lvl_r  <= pref_lvl_nxt;
      total_r     <= total_nxt;
      present_r   <= present_nxt;
      miss_r      <= miss_nxt;
      cur_r       <= cur_nxt;
      cur_done_r  <= cur_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pref_r         <= pref_nxt;
    grp_x_r        <= grp_x_nxt;
    grp_below_r    <= grp_below_nxt;
    out_total_r    <= out_total_nxt;
    out_present_r  <= out_present_nxt;
    out_decisive_r <= out_decisive_nxt;
    out_found_r    <= out_found_nxt;
    out_m_r        <= out_m_nxt;
  end

  assign busy               = (st_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_total_groups   = out_total_r;
  assign out_present_groups = out_present_r;
  assign out_decisive       = out_decisive_r;
  assign out_found          = out_found_r;
  assign out_member_a       = out_m_r[0];
  assign out_member_b       = out_m_r[1];
  assign out_member_c       = out_m_r[2];
  assign out_member_d       = out_m_r[3];

  // A result only follows a taken item or a running scan
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(start && !busy) || $past(st_r != ST_IDLE)))
    else $error("result without a request");

  // Group rows return only while scanning
  a_grp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    grp_vld_r |-> (st_r == ST_SCAN || st_r == ST_OUTER))
    else $error("group row returned outside a scan");

  // Prefix and group reads never share a return cycle
  a_tags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(grp_vld_r && pref_vld_r))
    else $error("prefix and group read overlap");

  // Prefix fetch never runs past the last prefix level
  a_pre_level: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PRE) |-> (pre_lvl_r <= lvl_last))
    else $error("prefix level out of range");

endmodule
